[hdl/imu_pkg.sv]
package imu_pkg;

    // field widths
    localparam int TW = 63;           // timestamp
    localparam int VW = 32;           // axis value, signed Q16.16
    localparam int PW = 95;           // exact product |a1 - a0| * (tg - t0)
    localparam int QW = 41;           // saturated quotient, holds 2^40
    localparam int MUL_STEPS = 4;     // 16-bit chunks of the 64-bit time span
    localparam int DIV_STEPS = PW;    // one quotient bit per cycle
    localparam int CW = 7;            // step counter
    localparam logic [QW-1:0] QCAP = {1'b1, {(QW-1){1'b0}}};

    // sample kinds
    localparam logic OP_ACCEL = 1'b0;
    localparam logic OP_GYRO  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_FIN,
        S_PUT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr;        // store gyro word in the buffer
        logic set_ref;   // incoming accel becomes reference at once
        logic cap_new;   // hold incoming accel for a flush
        logic load;      // load lanes from buffer entry
        logic mul;       // one multiply chunk
        logic div;       // one division step
        logic fin;       // round, add and saturate
        logic put;       // load the output register
        logic last;      // final word of the run
        logic adopt;     // held accel becomes reference
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic t_ok;      // incoming time at or after reference time
        logic out_free;  // output register can take a word
    } t_sts;

endpackage

[hdl/imu_ram.sv]
module imu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/imu_lerp.sv]
module imu_lerp (
    input  logic                          i_clk,
    input  imu_pkg::t_cmd                 i_cmd,
    input  logic signed [imu_pkg::VW-1:0] i_a0,
    input  logic signed [imu_pkg::VW-1:0] i_a1,
    input  logic [imu_pkg::TW-1:0]        i_t0,
    input  logic [imu_pkg::TW-1:0]        i_t1,
    input  logic [imu_pkg::TW-1:0]        i_tg,
    output logic signed [imu_pkg::VW-1:0] o_res
);

    localparam int VW = imu_pkg::VW;
    localparam int TW = imu_pkg::TW;
    localparam int PW = imu_pkg::PW;
    localparam int QW = imu_pkg::QW;
    localparam int SW = QW + 3;

    logic [VW:0]          r_mag;
    logic                 r_neg;
    logic                 r_eq;
    logic [TW-1:0]        r_dv;
    logic [TW:0]          r_n;
    logic [PW-1:0]        r_acc;
    logic [TW-1:0]        r_rem;
    logic [QW-1:0]        r_q;
    logic signed [VW-1:0] r_a0;
    logic signed [VW-1:0] r_res;

    logic signed [VW:0]   n_d;
    logic [VW:0]          n_mag;
    logic [VW+15:0]       n_prod;
    logic [TW:0]          n_trial;
    logic                 n_qb;
    logic [QW:0]          n_qs;
    logic                 n_round;
    logic [QW:0]          n_qr;
    logic signed [SW-1:0] n_sum;

    // operand set-up
    always_comb begin
        n_d   = {i_a1[VW-1], i_a1} - {i_a0[VW-1], i_a0};
        n_mag = n_d[VW] ? (VW+1)'(-n_d) : n_d;
    end

    // multiply chunk and division step
    always_comb begin
        n_prod  = r_mag * r_n[TW:TW-15];
        n_trial = {r_rem, r_acc[PW-1]};
        n_qb    = (n_trial >= {1'b0, r_dv});
        n_qs    = {r_q, n_qb};
        if (n_qs > {1'b0, imu_pkg::QCAP}) begin
            n_qs = {1'b0, imu_pkg::QCAP};
        end
    end

    // rounding, sign and saturation
    always_comb begin
        n_round = ({r_rem, 1'b0} >= {1'b0, r_dv});
        n_qr    = {1'b0, r_q} + (QW+1)'(n_round);
        if (r_neg) begin
            n_sum = SW'(r_a0) - SW'(signed'({1'b0, n_qr}));
        end else begin
            n_sum = SW'(r_a0) + SW'(signed'({1'b0, n_qr}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= n_mag;
            r_a0  <= i_a0;
            r_eq  <= (i_t1 == i_t0);
            if (i_t1 > i_t0) begin
                r_dv  <= i_t1 - i_t0;
                r_neg <= n_d[VW];
            end else begin
                r_dv  <= i_t0 - i_t1;
                r_neg <= ~n_d[VW];
            end
            r_n   <= {1'b0, i_tg - i_t0};
            r_acc <= '0;
            r_rem <= '0;
            r_q   <= '0;
        end else if (i_cmd.mul) begin
            r_acc <= (r_acc << 16) + PW'(n_prod);
            r_n   <= r_n << 16;
        end else if (i_cmd.div) begin
            r_acc <= r_acc << 1;
            r_rem <= n_qb ? TW'(n_trial - {1'b0, r_dv}) : n_trial[TW-1:0];
            r_q   <= n_qs[QW-1:0];
        end
        if (i_cmd.fin) begin
            if (r_eq) begin
                r_res <= r_a0;
            end else if (n_sum > SW'(32'sh7fffffff)) begin
                r_res <= 32'sh7fffffff;
            end else if (n_sum < -SW'(33'sh080000000)) begin
                r_res <= 32'sh80000000;
            end else begin
                r_res <= n_sum[VW-1:0];
            end
        end
    end

    assign o_res = r_res;

endmodule

[hdl/imu_ctrl.sv]
module imu_ctrl #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_op,
    input  imu_pkg::t_sts i_sts,
    output logic          o_ready,
    output imu_pkg::t_cmd o_cmd,
    output logic [AW-1:0] o_waddr,
    output logic [AW-1:0] o_raddr
);

    localparam int NW = $clog2(DEPTH + 1);
    localparam int CW = imu_pkg::CW;

    imu_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_k;
    logic [NW-1:0]   r_count;
    logic            r_acc_valid;
    logic            is_last;

    assign is_last = (NW'(r_k) + NW'(1)) == r_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            imu_pkg::S_IDLE: begin
                if (i_valid && i_op == imu_pkg::OP_ACCEL && r_acc_valid && r_count != '0) begin
                    n_state = imu_pkg::S_RD;
                end
            end
            imu_pkg::S_RD:   n_state = imu_pkg::S_LOAD;
            imu_pkg::S_LOAD: n_state = imu_pkg::S_MUL;
            imu_pkg::S_MUL: begin
                if (r_cnt == CW'(imu_pkg::MUL_STEPS - 1)) begin
                    n_state = imu_pkg::S_DIV;
                end
            end
            imu_pkg::S_DIV: begin
                if (r_cnt == CW'(imu_pkg::DIV_STEPS - 1)) begin
                    n_state = imu_pkg::S_FIN;
                end
            end
            imu_pkg::S_FIN:  n_state = imu_pkg::S_PUT;
            imu_pkg::S_PUT: begin
                if (i_sts.out_free) begin
                    n_state = is_last ? imu_pkg::S_IDLE : imu_pkg::S_RD;
                end
            end
            default: n_state = imu_pkg::S_IDLE;
        endcase
        n_cnt = (n_state == r_state) ? r_cnt + CW'(1) : '0;
    end

    // commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            imu_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_op == imu_pkg::OP_GYRO) begin
                        o_cmd.wr = r_acc_valid && i_sts.t_ok && (r_count < NW'(DEPTH));
                    end else if (r_acc_valid && r_count != '0) begin
                        o_cmd.cap_new = 1'b1;
                    end else begin
                        o_cmd.set_ref = 1'b1;
                    end
                end
            end
            imu_pkg::S_LOAD: o_cmd.load = 1'b1;
            imu_pkg::S_MUL:  o_cmd.mul  = 1'b1;
            imu_pkg::S_DIV:  o_cmd.div  = 1'b1;
            imu_pkg::S_FIN:  o_cmd.fin  = 1'b1;
            imu_pkg::S_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.put   = 1'b1;
                    o_cmd.last  = is_last;
                    o_cmd.adopt = is_last;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_waddr = r_count[AW-1:0];
    assign o_raddr = r_k;

    // state, buffer fill and run index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imu_pkg::S_IDLE;
            r_cnt       <= '0;
            r_k         <= '0;
            r_count     <= '0;
            r_acc_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.wr) begin
                r_count <= r_count + NW'(1);
            end else if (o_cmd.adopt || o_cmd.set_ref) begin
                r_count <= '0;
            end
            if (o_cmd.set_ref) begin
                r_acc_valid <= 1'b1;
            end
            if (o_cmd.cap_new) begin
                r_k <= '0;
            end else if (o_cmd.put && !o_cmd.last) begin
                r_k <= r_k + AW'(1);
            end
        end
    end

endmodule

[hdl/imu_dp.sv]
module imu_dp #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  imu_pkg::t_cmd                 i_cmd,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [AW-1:0]                 i_raddr,
    input  logic [imu_pkg::TW-1:0]        i_time_ns,
    input  logic signed [imu_pkg::VW-1:0] i_x,
    input  logic signed [imu_pkg::VW-1:0] i_y,
    input  logic signed [imu_pkg::VW-1:0] i_z,
    input  logic                          i_ready,
    output imu_pkg::t_sts                 o_sts,
    output logic                          o_valid,
    output logic signed [imu_pkg::VW-1:0] o_accel_x,
    output logic signed [imu_pkg::VW-1:0] o_accel_y,
    output logic signed [imu_pkg::VW-1:0] o_accel_z,
    output logic signed [imu_pkg::VW-1:0] o_gyro_x,
    output logic signed [imu_pkg::VW-1:0] o_gyro_y,
    output logic signed [imu_pkg::VW-1:0] o_gyro_z,
    output logic [imu_pkg::TW-1:0]        o_sample_time,
    output logic                          o_last
);

    localparam int VW = imu_pkg::VW;
    localparam int TW = imu_pkg::TW;
    localparam int RW = TW + 3 * VW;

    logic [TW-1:0]        r_ref_t, r_new_t, r_g_t, r_o_t;
    logic signed [VW-1:0] r_ref_x, r_ref_y, r_ref_z;
    logic signed [VW-1:0] r_new_x, r_new_y, r_new_z;
    logic signed [VW-1:0] r_g_x, r_g_y, r_g_z;
    logic signed [VW-1:0] r_o_ax, r_o_ay, r_o_az, r_o_gx, r_o_gy, r_o_gz;
    logic                 r_o_last;
    logic                 r_o_valid;
    logic [RW-1:0]        rdata;
    logic [TW-1:0]        rd_t;
    logic signed [VW-1:0] res_x, res_y, res_z;

    // gyro buffer
    imu_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (i_waddr),
        .i_wdata ({i_time_ns, i_x, i_y, i_z}),
        .i_raddr (i_raddr),
        .o_rdata (rdata)
    );

    assign rd_t = rdata[RW-1 -: TW];

    // one interpolation lane per axis
    imu_lerp u_lerp_x (
        .i_clk (i_clk), .i_cmd (i_cmd), .i_a0 (r_ref_x), .i_a1 (r_new_x),
        .i_t0 (r_ref_t), .i_t1 (r_new_t), .i_tg (rd_t), .o_res (res_x)
    );
    imu_lerp u_lerp_y (
        .i_clk (i_clk), .i_cmd (i_cmd), .i_a0 (r_ref_y), .i_a1 (r_new_y),
        .i_t0 (r_ref_t), .i_t1 (r_new_t), .i_tg (rd_t), .o_res (res_y)
    );
    imu_lerp u_lerp_z (
        .i_clk (i_clk), .i_cmd (i_cmd), .i_a0 (r_ref_z), .i_a1 (r_new_z),
        .i_t0 (r_ref_t), .i_t1 (r_new_t), .i_tg (rd_t), .o_res (res_z)
    );

    // accel reference, held accel and current gyro word
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_ref) begin
            r_ref_t <= i_time_ns;
            r_ref_x <= i_x;
            r_ref_y <= i_y;
            r_ref_z <= i_z;
        end else if (i_cmd.adopt) begin
            r_ref_t <= r_new_t;
            r_ref_x <= r_new_x;
            r_ref_y <= r_new_y;
            r_ref_z <= r_new_z;
        end
        if (i_cmd.cap_new) begin
            r_new_t <= i_time_ns;
            r_new_x <= i_x;
            r_new_y <= i_y;
            r_new_z <= i_z;
        end
        if (i_cmd.load) begin
            r_g_t <= rd_t;
            r_g_x <= rdata[3*VW-1 -: VW];
            r_g_y <= rdata[2*VW-1 -: VW];
            r_g_z <= rdata[VW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_o_ax   <= res_x;
            r_o_ay   <= res_y;
            r_o_az   <= res_z;
            r_o_gx   <= r_g_x;
            r_o_gy   <= r_g_y;
            r_o_gz   <= r_g_z;
            r_o_t    <= r_g_t;
            r_o_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_sts.t_ok     = (i_time_ns >= r_ref_t);
    assign o_sts.out_free = !r_o_valid || i_ready;

    assign o_valid       = r_o_valid;
    assign o_accel_x     = r_o_ax;
    assign o_accel_y     = r_o_ay;
    assign o_accel_z     = r_o_az;
    assign o_gyro_x      = r_o_gx;
    assign o_gyro_y      = r_o_gy;
    assign o_gyro_z      = r_o_gz;
    assign o_sample_time = r_o_t;
    assign o_last        = r_o_last;

endmodule

[hdl/imu_gyro_accel_interp_merge.sv]
// channel | valid   | ready   | payload
// input   | i_valid | o_ready | i_op, i_time_ns, i_x, i_y, i_z
// output  | o_valid | i_ready | o_accel_x/y/z, o_gyro_x/y/z, o_sample_time, o_last
//
// a gyro word or an accel word with an empty buffer is taken in idle and starts no flush
// an accel word flushing n buffered gyros works through these steps per gyro:
// buffer read, 4 multiply chunks, 95 restoring division steps, round, output
// each axis has its own division unit, which yields one quotient bit a cycle
// i_rst_n is synchronous; it clears the controller, fill count and output valid
// a stalled output holds the flush at that word; the last word may wait while
// new input words are taken
module imu_gyro_accel_interp_merge #(
    parameter int GYRO_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [imu_pkg::TW-1:0]        i_time_ns,
    input  logic signed [imu_pkg::VW-1:0] i_x,
    input  logic signed [imu_pkg::VW-1:0] i_y,
    input  logic signed [imu_pkg::VW-1:0] i_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [imu_pkg::VW-1:0] o_accel_x,
    output logic signed [imu_pkg::VW-1:0] o_accel_y,
    output logic signed [imu_pkg::VW-1:0] o_accel_z,
    output logic signed [imu_pkg::VW-1:0] o_gyro_x,
    output logic signed [imu_pkg::VW-1:0] o_gyro_y,
    output logic signed [imu_pkg::VW-1:0] o_gyro_z,
    output logic [imu_pkg::TW-1:0]        o_sample_time,
    output logic                          o_last
);

    localparam int AW = (GYRO_DEPTH > 1) ? $clog2(GYRO_DEPTH) : 1;

    imu_pkg::t_cmd cmd;
    imu_pkg::t_sts sts;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    // controller
    imu_ctrl #(
        .DEPTH (GYRO_DEPTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd),
        .o_waddr (waddr),
        .o_raddr (raddr)
    );

    // datapath
    imu_dp #(
        .DEPTH (GYRO_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_waddr       (waddr),
        .i_raddr       (raddr),
        .i_time_ns     (i_time_ns),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_z           (i_z),
        .i_ready       (i_ready),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_accel_x     (o_accel_x),
        .o_accel_y     (o_accel_y),
        .o_accel_z     (o_accel_z),
        .o_gyro_x      (o_gyro_x),
        .o_gyro_y      (o_gyro_y),
        .o_gyro_z      (o_gyro_z),
        .o_sample_time (o_sample_time),
        .o_last        (o_last)
    );

endmodule

[hdl/imu_chk.sv]
module imu_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          i_op,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [imu_pkg::TW-1:0]        o_sample_time,
    input logic signed [imu_pkg::VW-1:0] o_accel_x,
    input logic                          o_last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_time) && $stable(o_accel_x))
        else $error("output word changed while stalled");

    // no input is taken while a non-last output word of a run is valid
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input taken during a flush");

    // a gyro word never starts an output word
    a_gyro_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_op == imu_pkg::OP_GYRO |=> !$rose(o_valid))
        else $error("output after a gyro word");

    // reset leaves no output word pending
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word pending after reset");

endmodule

bind imu_gyro_accel_interp_merge imu_chk u_chk (.*);
